### rtl/word_crc32_engine_defines.svh
// -----------------------------------------------------------------------------
// word_crc32_engine_defines
// Assertion macros shared by the word CRC engine RTL.
// -----------------------------------------------------------------------------
`ifndef WORD_CRC32_ENGINE_DEFINES_SVH
`define WORD_CRC32_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WCRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define WCRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/wcrc_pkg.sv
// -----------------------------------------------------------------------------
// wcrc_pkg
// Types, constants and the byte-step table for the word CRC engine.
// -----------------------------------------------------------------------------
package wcrc_pkg;

   localparam int unsigned WORD_W = 32;
   localparam logic [WORD_W-1:0] CRC_POLY   = 32'h04C1_1DB7;
   localparam logic [WORD_W-1:0] CRC_TOPBIT = 32'h8000_0000;
   localparam int unsigned BYTE_STEPS = 3;

   typedef logic [WORD_W-1:0] crc_word_type;
   typedef crc_word_type crc_table_type [256];

   // Marks that travel with one word.
   typedef struct packed {
      logic first;
      logic last;
   } word_flags_type;

   // Entry i: byte i in the top lane shifted through eight polynomial steps.
   function automatic crc_table_type build_crc_table();
      crc_table_type tbl;
      crc_word_type  t;
      for (int i = 0; i < 256; i++) begin
         t = {8'(i), 24'h0};
         for (int b = 0; b < 8; b++) begin
            if ((t & CRC_TOPBIT) != '0) begin
               t = {t[WORD_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
               t = {t[WORD_W-2:0], 1'b0};
            end
         end
         tbl[i] = t;
      end
      return tbl;
   endfunction

   localparam crc_table_type CRC_TABLE = build_crc_table();

   // One MSB-first byte step with a zero input byte.
   function automatic crc_word_type crc_byte_step(crc_word_type v);
      return CRC_TABLE[v[WORD_W-1 -: 8]] ^ {v[WORD_W-9:0], 8'h00};
   endfunction

endpackage

### rtl/wcrc_in_stage.sv
// -----------------------------------------------------------------------------
// wcrc_in_stage
// Input register: holds one accepted word and its marks until it advances.
// -----------------------------------------------------------------------------
module wcrc_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  wcrc_pkg::crc_word_type req_tdata,
   input  logic                   req_tuser,
   input  logic                   req_tlast,
   input  logic                   advance,
   output logic                   hold_valid,
   output wcrc_pkg::word_flags_type hold_flags,
   output wcrc_pkg::crc_word_type hold_word
);
   import wcrc_pkg::*;

   logic           valid_ff, valid_in;
   word_flags_type flags_ff;
   crc_word_type   word_ff;
   logic           accept;

   // Take a new word whenever the slot is empty or drains this cycle.
   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign valid_in   = accept || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff        <= req_tdata;
         flags_ff.first <= req_tuser;
         flags_ff.last  <= req_tlast;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_flags = flags_ff;
   assign hold_word  = word_ff;

endmodule

### rtl/wcrc_core.sv
// -----------------------------------------------------------------------------
// wcrc_core
// Running CRC register and its single-pass update: load or three byte steps.
// -----------------------------------------------------------------------------
module wcrc_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  wcrc_pkg::word_flags_type flags,
   input  wcrc_pkg::crc_word_type   word,
   output wcrc_pkg::crc_word_type   crc_next,
   output wcrc_pkg::crc_word_type   crc_cur
);
   import wcrc_pkg::*;

   crc_word_type running_crc_ff, running_crc_in;
   crc_word_type stepped;

   always_comb begin
      stepped = running_crc_ff;
      for (int k = 0; k < BYTE_STEPS; k++) begin
         stepped = crc_byte_step(stepped);
      end
   end

   // First word reloads; later words fold in after the byte steps.
   assign crc_next       = flags.first ? ~word : (stepped ^ word);
   assign running_crc_in = advance ? crc_next : running_crc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= '0;
      end else begin
         running_crc_ff <= running_crc_in;
      end
   end

   assign crc_cur = running_crc_ff;

endmodule

### rtl/wcrc_out_stage.sv
// -----------------------------------------------------------------------------
// wcrc_out_stage
// Result register: holds the inverted checksum until the receiver takes it.
// -----------------------------------------------------------------------------
module wcrc_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  wcrc_pkg::crc_word_type load_value,
   output logic                   slot_free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output wcrc_pkg::crc_word_type rsp_tdata
);
   import wcrc_pkg::*;

   logic         valid_ff, valid_in;
   crc_word_type data_ff;

   assign slot_free = !valid_ff || rsp_tready;
   assign valid_in  = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_value;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

### rtl/word_crc32_engine.sv
// -----------------------------------------------------------------------------
// word_crc32_engine
// Word-wide CRC engine, polynomial 0x04C11DB7, MSB first, three byte steps.
// -----------------------------------------------------------------------------
// Usage:
//   Feed message words on the req_ channel. req_tuser high marks the first
//   word of a message, req_tlast high marks the last one. A first word loads
//   the running value with its inverse; every other word advances the running
//   value by three table-driven byte steps and then XORs the word in.
//   Only a word with req_tlast produces a result on the rsp_ channel: the
//   inverted running value. Other words produce nothing.
// Timing:
//   A word is taken every cycle while req_tready is high. A result reaches
//   rsp_tvalid through the input register and then the result register;
//   the three byte steps are one combinational pass between them.
// Stalls:
//   While rsp_tready is low the result register holds its word. Words that
//   carry no last mark keep flowing; a last word waits in the input register
//   until the result register frees up, and req_tready drops behind it.
// Reset:
//   Synchronous, active high. Clears both valid flags and sets the running
//   value to zero; the running value is otherwise kept across messages.
// -----------------------------------------------------------------------------
`include "word_crc32_engine_defines.svh"

module word_crc32_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  wcrc_pkg::crc_word_type req_tdata,   // [31:0] data_word
   input  logic                   req_tuser,   // [0] first_word
   input  logic                   req_tlast,   // last_word
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output wcrc_pkg::crc_word_type rsp_tdata    // [31:0] crc_value
);
   import wcrc_pkg::*;

   logic           hold_valid;
   word_flags_type hold_flags;
   crc_word_type   hold_word;
   logic           advance;
   logic           out_free;
   logic           out_load;
   crc_word_type   crc_next;
   crc_word_type   crc_cur;

   // Advance the held word unless it needs the result slot and that is busy.
   assign advance  = hold_valid && (!hold_flags.last || out_free);
   assign out_load = advance && hold_flags.last;

   wcrc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_flags (hold_flags),
      .hold_word  (hold_word)
   );

   wcrc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .flags    (hold_flags),
      .word     (hold_word),
      .crc_next (crc_next),
      .crc_cur  (crc_cur)
   );

   // Emit the inverse of the updated running value.
   wcrc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .load_value (~crc_next),
      .slot_free  (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A last word that advances must show up as a pending result next cycle.
   `WCRC_ASSERT_NEXT(a_last_yields_result, clock, reset, out_load, rsp_tvalid, "last word lost")

   // A held word that cannot advance must still be held next cycle.
   `WCRC_ASSERT_NEXT(a_held_word_kept, clock, reset, hold_valid && !advance, hold_valid, "held word dropped")

   // A first word reloads the running value with its inverse.
   `WCRC_ASSERT_NEXT(a_first_reloads, clock, reset, advance && hold_flags.first, crc_cur == ~$past(hold_word), "first word did not reload")

   // An empty input register always takes a word.
   `WCRC_ASSERT_NOW(a_empty_ready, clock, reset, !hold_valid, req_tready, "empty stage not ready")

endmodule

### dv/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the word CRC engine: a short table of directed
// words, then random messages under several idle and stall patterns, each
// result matched in order against a bit-serial CRC tracker kept in the bench.
// -----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import wcrc_pkg::crc_word_type;

   // Generator polynomial, MSB first, and byte folds per continuation word.
   localparam crc_word_type GEN_POLY   = 32'h04C1_1DB7;
   localparam int           FOLD_STEPS = 3;

   localparam int RANDOM_WORDS = 650;
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 20;    // idle time after the last result
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_MAX   = 10;

   // One directed word; typed_crc is used only where has_typed is set.
   typedef struct packed {
      crc_word_type data;
      logic         first;
      logic         last;
      logic         has_typed;
      crc_word_type typed_crc;
   } word_row_t;

   localparam int ROW_COUNT = 18;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   crc_word_type req_tdata = '0;    // [31:0] data_word
   logic         req_tuser = 1'b0;  // [0] first_word
   logic         req_tlast = 1'b0;  // last_word
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   crc_word_type rsp_tdata;         // [31:0] crc_value

   crc_word_type crc_track = '0;    // running value as the bench sees it
   crc_word_type crc_pending[$];    // CRCs still owed by the block
   word_row_t    directed_rows [ROW_COUNT];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_go = 1'b0;
   int  hold_left = 0;
   int  cycle_count = 0;
   int  error_count = 0;
   int  words_sent = 0;
   int  results_seen = 0;
   int  messages_sent = 0;

   word_crc32_engine DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Advance a running value by the fixed number of zero-byte folds, one bit
   // at a time, so the check never leans on a lookup table.
   function automatic crc_word_type crc_fold(crc_word_type v);
      crc_word_type top;
      for (int s = 0; s < FOLD_STEPS; s++) begin
         top = {v[31:24], 24'h0};
         for (int b = 0; b < 8; b++) begin
            if (top[31]) begin
               top = {top[30:0], 1'b0} ^ GEN_POLY;
            end else begin
               top = {top[30:0], 1'b0};
            end
         end
         v = top ^ {v[23:0], 8'h00};
      end
      return v;
   endfunction

   // Favor corner words now and then: all zeros, all ones, one hot.
   function automatic crc_word_type pick_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return crc_word_type'(1) << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   function automatic void note_error(string what, crc_word_type exp_crc,
                                      crc_word_type got_crc);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("%0t: %s expected %08h actual %08h", $realtime, what, exp_crc,
                  got_crc);
      end
   endfunction

   // Offer one word, hold it until taken, then update the tracker. Idle
   // cycles go in front of the word so valid never drops while it waits.
   task automatic send_word(crc_word_type data, logic first, logic last,
                            logic has_typed, crc_word_type typed_crc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (first) begin
         crc_track = ~data;
      end else begin
         crc_track = crc_fold(crc_track) ^ data;
      end
      if (last) begin
         crc_pending.push_back(has_typed ? typed_crc : ~crc_track);
      end
      words_sent++;
   endtask

   // Mostly well-formed messages; a noisy one scatters first and last marks.
   task automatic send_message(int len, bit noisy);
      logic first;
      logic last;
      for (int i = 0; i < len; i++) begin
         first = (i == 0);
         last  = (i == len - 1);
         if (noisy) begin
            first = 1'($urandom_range(1));
            last  = 1'($urandom_range(1));
         end
         send_word(pick_word(), first, last, 1'b0, '0);
      end
      messages_sent++;
   endtask

   task automatic run_random(int word_goal);
      int len;
      while (words_sent < word_goal) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
         send_message(len, $urandom_range(9) == 0);
      end
   endtask

   // Receiver: check each taken result against the oldest expected CRC,
   // then pick tready for the next cycle. A hold-off request keeps tready
   // low for a counted stretch.
   always @(posedge clock) begin
      crc_word_type exp_crc;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (crc_pending.size() == 0) begin
            note_error("result with none expected:", '0, rsp_tdata);
         end else begin
            exp_crc = crc_pending.pop_front();
            if (rsp_tdata !== exp_crc) begin
               note_error("crc_value mismatch:", exp_crc, rsp_tdata);
            end
         end
      end
      if (hold_go) begin
         hold_go   = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Time out: a stuck handshake or a lost result ends here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d CRCs outstanding", cycle_count,
               crc_pending.size());
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      // Directed words. Typed CRCs: after reset the running value is zero, so
      // an unmarked last word yields its own inverse; a one-word message
      // yields the word itself.
      directed_rows = '{
         '{32'h1234_5678, 1'b0, 1'b1, 1'b1, 32'hEDCB_A987},  // no first mark after reset
         '{32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'h0000_0000},  // single word, zeros
         '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},  // single word, ones
         '{32'hA5A5_A5A5, 1'b1, 1'b1, 1'b1, 32'hA5A5_A5A5},
         '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0},          // four-word message
         '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
         '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
         '{32'h0000_0001, 1'b0, 1'b1, 1'b0, 32'h0},
         '{32'hDEAD_BEEF, 1'b0, 1'b1, 1'b0, 32'h0},          // continue past a last word
         '{32'h1111_1111, 1'b1, 1'b0, 1'b0, 32'h0},
         '{32'h2222_2222, 1'b1, 1'b0, 1'b0, 32'h0},          // restart mid-message
         '{32'h3333_3333, 1'b0, 1'b0, 1'b0, 32'h0},
         '{32'h4444_4444, 1'b0, 1'b1, 1'b0, 32'h0},
         '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0},          // all-zero message
         '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
         '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0},
         '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0},          // all-ones message
         '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].data, directed_rows[i].first, directed_rows[i].last,
                   directed_rows[i].has_typed, directed_rows[i].typed_crc);
      end

      // Back-pressure: stall the result side for a long stretch while single
      // word messages keep coming, so the block fills and drops req_tready.
      hold_go = 1'b1;
      for (int i = 0; i < 30; i++) begin
         send_message(1, 1'b0);
      end

      // Random traffic in four idle patterns.
      run_random(words_sent + RANDOM_WORDS / 4);
      send_idle_pct = 52;
      run_random(words_sent + RANDOM_WORDS / 4);
      send_idle_pct  = 0;
      recv_stall_pct = 52;
      run_random(words_sent + RANDOM_WORDS / 4);
      send_idle_pct  = 37;
      recv_stall_pct = 37;
      run_random(words_sent + RANDOM_WORDS / 4);

      req_tvalid <= 1'b0;
      while (crc_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d words in %0d random messages plus directed rows, %0d CRCs checked",
               words_sent, messages_sent, results_seen);
      $display("phases: no idling, sender idle, receiver stall, both, long hold-off; %0d errors",
               error_count);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
